[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[design/ple_pkg.sv]
// Types and constants of the positional list engine.
package ple_pkg;

  // List storage
  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W      = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam int DATA_W     = 32;

  // Result search tree: groups of cells, then one merge over the groups
  localparam int GRP_SIZE   = 8;
  localparam int GRP_W      = $clog2(GRP_SIZE);
  localparam int NUM_GRP    = (LIST_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_DEPTH  = NUM_GRP * GRP_SIZE;
  localparam int GIDX_W     = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int PIDX_W     = $clog2(PAD_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_READ   = 3'd3,
    OP_FIND   = 3'd4,
    OP_INS_AT = 3'd5,
    OP_DELETE = 3'd6
  } ple_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } ple_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_GROUP,
    FSM_MERGE
  } ple_fsm_e;

  // Command broadcast to every cell
  typedef struct packed {
    logic              go;
    logic              ins;
    logic              del;
    logic              find;
    logic              rd;
    logic [IDX_W-1:0]  at;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } ple_cell_cmd_t;

  // First hit within one group of cells
  typedef struct packed {
    logic              any;
    logic [GRP_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } ple_grp_t;

endpackage

[design/positional_list_engine_unit.sv]
// Top level of the positional list engine: control, cell chain, result merge.
//
// Ordered list of up to LIST_DEPTH signed 32-bit entries held in a chain of
// cells. One input word carries an operation (clear, head insert, tail
// append, read at position, find value, insert at position, delete at
// position), a 1-based position and a value. Each input word gives exactly
// one result word: status, value, found position and list length.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Insert and delete shift the cells from the position onward in the
// accept cycle; every cell compares against the search value in parallel.
// A result passes the cell hit register, the group register and the
// output register. The block takes one word at a time: it accepts the
// next only once the last has left the group and merge stages of the tree.
// in_stall_o is high while a word is in flight. A stalled result sits in
// the output register; a word accepted meanwhile waits in the merge stage
// until the output register frees up.
// Reset empties the list (length zero); entry contents are not cleared.
`include "assert_macros.svh"

module positional_list_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_out_o,
  output logic [6:0]         found_position_o,
  output logic [6:0]         length_o
);

  localparam int CMP_W = ple_pkg::CMP_W;
  localparam int CNT_W = ple_pkg::CNT_W;

  ple_pkg::ple_fsm_e state_q, state_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   load_out;

  logic [CNT_W-1:0]       count_q, count_d;
  ple_pkg::ple_cell_cmd_t cmd;
  ple_pkg::ple_status_e   status_d, pend_status_q;
  logic                   find_d, pend_find_q;
  logic                   rd_d, pend_rd_q;
  logic [31:0]            pend_val_q;

  logic [CMP_W-1:0]       cnt_x, pos_x, ins_pos;
  ple_pkg::ple_op_e       op;

  logic [ple_pkg::PAD_DEPTH-1:0] hit;
  logic [ple_pkg::DATA_W-1:0]    cell_data [ple_pkg::PAD_DEPTH];
  ple_pkg::ple_grp_t             grp [ple_pkg::NUM_GRP];

  logic                        sel_any;
  logic [ple_pkg::GIDX_W-1:0]  sel_g;
  logic [ple_pkg::GRP_W-1:0]   sel_local;
  logic [31:0]                 sel_data;
  logic [ple_pkg::PIDX_W-1:0]  sel_pos;

  ple_pkg::ple_status_e res_status;
  logic [31:0]          res_value;
  logic [6:0]           res_fpos;

  logic                 out_valid_q;
  ple_pkg::ple_status_e out_status_q;
  logic [31:0]          out_value_q;
  logic [6:0]           out_fpos_q;
  logic [6:0]           out_len_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode the input word against the current length
  always_comb begin
    op       = ple_pkg::ple_op_e'(operation_i);
    cnt_x    = CMP_W'(count_q);
    pos_x    = CMP_W'(position_i);
    cmd      = '0;
    cmd.go   = in_acc;
    cmd.count = count_q;
    cmd.value = value_i;
    count_d  = count_q;
    status_d = ple_pkg::ST_OK;
    find_d   = 1'b0;
    rd_d     = 1'b0;
    if (op == ple_pkg::OP_HEAD) begin
      ins_pos = CMP_W'(1);
    end else if (op == ple_pkg::OP_TAIL) begin
      ins_pos = cnt_x + CMP_W'(1);
    end else begin
      ins_pos = pos_x;
    end
    unique case (op)
      ple_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      ple_pkg::OP_HEAD, ple_pkg::OP_TAIL, ple_pkg::OP_INS_AT: begin
        if ((ins_pos == '0) || (ins_pos > cnt_x + CMP_W'(1))) begin
          status_d = ple_pkg::ST_BADPOS;
        end else if (cnt_x >= CMP_W'(ple_pkg::LIST_DEPTH)) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          cmd.ins = in_acc;
          cmd.at  = ple_pkg::IDX_W'(ins_pos - CMP_W'(1));
          count_d = count_q + CNT_W'(1);
        end
      end
      ple_pkg::OP_READ: begin
        if ((pos_x == '0) || (pos_x > cnt_x)) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          cmd.rd = 1'b1;
          cmd.at = ple_pkg::IDX_W'(pos_x - CMP_W'(1));
          rd_d   = 1'b1;
        end
      end
      ple_pkg::OP_FIND: begin
        cmd.find = 1'b1;
        find_d   = 1'b1;
      end
      ple_pkg::OP_DELETE: begin
        if ((pos_x == '0) || (pos_x > cnt_x)) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          cmd.del = in_acc;
          cmd.at  = ple_pkg::IDX_W'(pos_x - CMP_W'(1));
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Length and pending result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_acc) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_status_q <= status_d;
      pend_find_q   <= find_d;
      pend_rd_q     <= rd_d;
      pend_val_q    <= value_i;
    end
  end

  // Cell chain, padded to whole groups
  for (genvar k = 0; k < ple_pkg::PAD_DEPTH; k++) begin : g_cell
    if (k < ple_pkg::LIST_DEPTH) begin : g_real
      logic [ple_pkg::DATA_W-1:0] left_data, right_data;
      if (k == 0) begin : g_first
        assign left_data = value_i;
      end else begin : g_mid_l
        assign left_data = cell_data[k-1];
      end
      if (k == ple_pkg::LIST_DEPTH - 1) begin : g_last
        assign right_data = cell_data[k];
      end else begin : g_mid_r
        assign right_data = cell_data[k+1];
      end
      ple_cell u_cell (
        .clk_i        (clk_i),
        .cmd_i        (cmd),
        .idx_i        (ple_pkg::IDX_W'(k)),
        .left_data_i  (left_data),
        .right_data_i (right_data),
        .data_o       (cell_data[k]),
        .hit_o        (hit[k])
      );
    end else begin : g_pad
      assign cell_data[k] = '0;
      assign hit[k]       = 1'b0;
    end
  end

  // First stage of the search tree
  for (genvar g = 0; g < ple_pkg::NUM_GRP; g++) begin : g_grp
    ple_group u_group (
      .clk_i  (clk_i),
      .hit_i  (hit[g*ple_pkg::GRP_SIZE +: ple_pkg::GRP_SIZE]),
      .data_i (cell_data[g*ple_pkg::GRP_SIZE +: ple_pkg::GRP_SIZE]),
      .grp_o  (grp[g])
    );
  end

  // Merge over groups: lowest group with a hit
  always_comb begin
    sel_any   = 1'b0;
    sel_g     = '0;
    sel_local = '0;
    sel_data  = '0;
    for (int g = ple_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp[g].any) begin
        sel_any   = 1'b1;
        sel_g     = ple_pkg::GIDX_W'(g);
        sel_local = grp[g].idx;
        sel_data  = grp[g].data;
      end
    end
    sel_pos = (ple_pkg::PIDX_W'(sel_g) << ple_pkg::GRP_W) +
              ple_pkg::PIDX_W'(sel_local) + ple_pkg::PIDX_W'(1);
  end

  // Result word
  always_comb begin
    res_status = pend_status_q;
    res_value  = '0;
    res_fpos   = '0;
    if (pend_find_q) begin
      if (sel_any) begin
        res_status = ple_pkg::ST_OK;
        res_value  = pend_val_q;
        res_fpos   = 7'(sel_pos);
      end else begin
        res_status = ple_pkg::ST_NOTFOUND;
      end
    end else if (pend_rd_q) begin
      res_value = sel_data;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::FSM_IDLE:  if (in_valid_i) state_d = ple_pkg::FSM_GROUP;
      ple_pkg::FSM_GROUP: state_d = ple_pkg::FSM_MERGE;
      ple_pkg::FSM_MERGE: if (out_free) state_d = ple_pkg::FSM_IDLE;
      default:            state_d = ple_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      ple_pkg::FSM_IDLE:  in_stall_o = 1'b0;
      ple_pkg::FSM_GROUP: in_stall_o = 1'b1;
      ple_pkg::FSM_MERGE: load_out   = out_free;
      default:            in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
      out_fpos_q   <= res_fpos;
      out_len_q    <= 7'(count_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign value_out_o      = $signed(out_value_q);
  assign found_position_o = out_fpos_q;
  assign length_o         = out_len_q;

  // Checks
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(ple_pkg::LIST_DEPTH))
  `ASSERT_PROP(a_accept_starts, clk_i, rst_ni, in_acc |=> state_q == ple_pkg::FSM_GROUP)
  `ASSERT_PROP(a_count_hold, clk_i, rst_ni, !in_acc |=> $stable(count_q))
  `ASSERT_PROP(a_merge_loads, clk_i, rst_ni, load_out |=> out_valid_q)

endmodule

[design/ple_cell.sv]
// One list cell: holds an entry, shifts with its neighbors, flags a hit.
module ple_cell (
  input  logic                  clk_i,
  input  ple_pkg::ple_cell_cmd_t cmd_i,
  input  logic [ple_pkg::IDX_W-1:0]  idx_i,
  input  logic [ple_pkg::DATA_W-1:0] left_data_i,
  input  logic [ple_pkg::DATA_W-1:0] right_data_i,
  output logic [ple_pkg::DATA_W-1:0] data_o,
  output logic                  hit_o
);

  logic [ple_pkg::DATA_W-1:0] data_q, data_d;
  logic                       hit_q, hit_d;
  logic                       in_list;

  assign in_list = ple_pkg::CNT_W'(idx_i) < cmd_i.count;

  // Shift right on insert, left on delete
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i > cmd_i.at) begin
        data_d = left_data_i;
      end else if (idx_i == cmd_i.at) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.del && (idx_i >= cmd_i.at)) begin
      data_d = right_data_i;
    end
  end

  // Hit: addressed cell on read, first-match candidate on find
  always_comb begin
    hit_d = hit_q;
    if (cmd_i.go) begin
      hit_d = (cmd_i.rd && (idx_i == cmd_i.at)) ||
              (cmd_i.find && in_list && (data_q == cmd_i.value));
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

[design/ple_group.sv]
// First hit and its data within one group of cells, registered.
module ple_group (
  input  logic                       clk_i,
  input  logic [ple_pkg::GRP_SIZE-1:0] hit_i,
  input  logic [ple_pkg::DATA_W-1:0] data_i [ple_pkg::GRP_SIZE],
  output ple_pkg::ple_grp_t          grp_o
);

  ple_pkg::ple_grp_t grp_q, grp_d;

  // Lowest index wins
  always_comb begin
    grp_d = '0;
    for (int i = ple_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (hit_i[i]) begin
        grp_d.any  = 1'b1;
        grp_d.idx  = ple_pkg::GRP_W'(i);
        grp_d.data = data_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

[tb/tb_positional_list_engine_unit.sv]
// Self-checking testbench of the positional list engine: directed table, then random sequences.
`timescale 1ns / 100ps

module tb_positional_list_engine_unit;

  // Opcode that the block leaves unused
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // Random stimulus shaping
  localparam int RANDOM_WORDS = 1400;
  localparam int BLOCK_WORDS  = 40;
  localparam int MODE_GROW    = 0;
  localparam int MODE_FILL    = 1;
  localparam int MODE_SHRINK  = 2;
  localparam int MODE_NOISE   = 3;
  localparam int MAX_GAP      = 10;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_AT     = 700;
  localparam int BURST_FROM   = 900;
  localparam int BURST_TO     = 1000;
  localparam int SETTLE       = 10;
  localparam int TIMEOUT_NS   = 3_000_000;

  typedef struct packed {
    ple_pkg::ple_status_e status;
    logic [31:0] value;
    logic [6:0]  fpos;
    logic [6:0]  len;
  } list_result_t;

  typedef struct {
    logic [2:0]         op;
    logic [6:0]         pos;
    logic signed [31:0] val;
    bit                 pinned;
    list_result_t       res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = 3'd0;
  logic [6:0]         position_i = 7'd0;
  logic signed [31:0] value_i = 32'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] value_out_o;
  logic [6:0]         found_position_o;
  logic [6:0]         length_o;

  // Shadow of the list contents
  logic signed [31:0] shadow_cells [ple_pkg::LIST_DEPTH];
  int                 shadow_len = 0;

  list_result_t       pending_results [$];
  stim_row_t          directed_rows [$];
  list_result_t       head_result;
  int                 mismatch_count = 0;
  bit                 no_idle = 1'b0;
  bit                 long_hold_req = 1'b0;

  positional_list_engine_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .found_position_o (found_position_o),
    .length_o         (length_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one operation to the shadow list and return the result word it gives
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                 logic signed [31:0] val);
    list_result_t r;
    int at;
    int k;
    bit hit;
    r.status = ple_pkg::ST_OK;
    r.value  = '0;
    r.fpos   = '0;
    hit      = 1'b0;
    case (op)
      ple_pkg::OP_CLEAR: shadow_len = 0;
      ple_pkg::OP_HEAD, ple_pkg::OP_TAIL, ple_pkg::OP_INS_AT: begin
        if (op == ple_pkg::OP_HEAD) at = 1;
        else if (op == ple_pkg::OP_TAIL) at = shadow_len + 1;
        else at = int'(pos);
        // position is checked before fullness
        if (at == 0 || at > shadow_len + 1) begin
          r.status = ple_pkg::ST_BADPOS;
        end else if (shadow_len >= ple_pkg::LIST_DEPTH) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (k = shadow_len; k >= at; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[at-1] = val;
          shadow_len++;
        end
      end
      ple_pkg::OP_READ: begin
        if (pos == 7'd0 || int'(pos) > shadow_len) r.status = ple_pkg::ST_BADPOS;
        else r.value = shadow_cells[pos-1];
      end
      ple_pkg::OP_FIND: begin
        r.status = ple_pkg::ST_NOTFOUND;
        for (k = 0; k < shadow_len && !hit; k++) begin
          if (shadow_cells[k] == val) begin
            hit      = 1'b1;
            r.status = ple_pkg::ST_OK;
            r.value  = val;
            r.fpos   = 7'(k + 1);
          end
        end
      end
      ple_pkg::OP_DELETE: begin
        if (pos == 7'd0 || int'(pos) > shadow_len) begin
          r.status = ple_pkg::ST_BADPOS;
        end else begin
          for (k = int'(pos) - 1; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    r.len = 7'(shadow_len);
    return r;
  endfunction

  // Mostly legal positions, with zero, one past the end and the top value mixed in
  function automatic logic [6:0] pick_position(logic [2:0] op);
    int top;
    int roll;
    top  = (op == ple_pkg::OP_INS_AT) ? shadow_len + 1 : shadow_len;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 7'd0;
    if (roll < 14) return (top + 1 > 64) ? 7'd64 : 7'(top + 1);
    if (roll < 18) return 7'd64;
    if (top == 0) return 7'd1;
    return 7'($urandom_range(1, (top > 64) ? 64 : top));
  endfunction

  // Extremes, a small pool for duplicates, list contents for finds, else random
  function automatic logic signed [31:0] pick_value(bit for_find);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      case (roll % 4)
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (roll < 30) return $urandom_range(0, 7) - 3;
    if (for_find && shadow_len > 0 && roll < 75)
      return shadow_cells[$urandom_range(0, shadow_len - 1)];
    return $urandom;
  endfunction

  task automatic table_row(logic [2:0] op, logic [6:0] pos, logic signed [31:0] val,
                           bit pinned, ple_pkg::ple_status_e st, logic [31:0] vout,
                           logic [6:0] fpos, logic [6:0] len);
    stim_row_t row;
    row.op         = op;
    row.pos        = pos;
    row.val        = val;
    row.pinned     = pinned;
    row.res.status = st;
    row.res.value  = vout;
    row.res.fpos   = fpos;
    row.res.len    = len;
    directed_rows.push_back(row);
  endtask

  // Offer one input word; returns at the edge where it is taken, valid still high
  task automatic offer_word(logic [2:0] op, logic [6:0] pos, logic signed [31:0] val,
                            bit pinned, list_result_t pinned_res);
    int gap;
    list_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_list_op(op, pos, val);
    pending_results.push_back(pinned ? pinned_res : predicted);
  endtask

  // One random word, shaped by the current sequence mode
  task automatic random_word(int mode);
    logic [2:0] op;
    logic [6:0] pos;
    logic signed [31:0] val;
    int roll;
    list_result_t unused_res;
    unused_res = '0;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (roll < 18) op = ple_pkg::OP_HEAD;
        else if (roll < 36) op = ple_pkg::OP_TAIL;
        else if (roll < 60) op = ple_pkg::OP_INS_AT;
        else if (roll < 72) op = ple_pkg::OP_READ;
        else if (roll < 86) op = ple_pkg::OP_FIND;
        else if (roll < 98) op = ple_pkg::OP_DELETE;
        else if (roll < 99) op = ple_pkg::OP_CLEAR;
        else op = OP_UNUSED;
      end
      MODE_FILL: begin
        if (roll < 25) op = ple_pkg::OP_HEAD;
        else if (roll < 50) op = ple_pkg::OP_TAIL;
        else if (roll < 85) op = ple_pkg::OP_INS_AT;
        else if (roll < 92) op = ple_pkg::OP_READ;
        else op = ple_pkg::OP_FIND;
      end
      MODE_SHRINK: begin
        if (roll < 6) op = ple_pkg::OP_HEAD;
        else if (roll < 12) op = ple_pkg::OP_TAIL;
        else if (roll < 20) op = ple_pkg::OP_INS_AT;
        else if (roll < 34) op = ple_pkg::OP_READ;
        else if (roll < 50) op = ple_pkg::OP_FIND;
        else if (roll < 98) op = ple_pkg::OP_DELETE;
        else if (roll < 99) op = ple_pkg::OP_CLEAR;
        else op = OP_UNUSED;
      end
      default: op = 3'($urandom_range(0, 7));
    endcase
    if (mode == MODE_NOISE) begin
      pos = 7'($urandom_range(0, 64));
    end else if (op == ple_pkg::OP_READ || op == ple_pkg::OP_INS_AT ||
                 op == ple_pkg::OP_DELETE) begin
      pos = pick_position(op);
    end else begin
      pos = 7'($urandom_range(0, 64));
    end
    val = (mode == MODE_NOISE && roll < 50) ? $urandom : pick_value(op == ple_pkg::OP_FIND);
    offer_word(op, pos, val, 1'b0, unused_res);
  endtask

  // Result side: random stall per word, one long hold on request
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, status_o);
          mismatch_count++;
        end
        if (value_out_o !== head_result.value) begin
          $error("value_out: expected %0h, got %0h", head_result.value, value_out_o);
          mismatch_count++;
        end
        if (found_position_o !== head_result.fpos) begin
          $error("found_position: expected %0d, got %0d", head_result.fpos,
                 found_position_o);
          mismatch_count++;
        end
        if (length_o !== head_result.len) begin
          $error("length: expected %0d, got %0d", head_result.len, length_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int n;
    int mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; pinned rows carry their result, the rest go to the predictor
    table_row(ple_pkg::OP_READ,   7'd1,  32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_FIND,   7'd0,  32'sd5,        1'b1, ple_pkg::ST_NOTFOUND,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_DELETE, 7'd0,  32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_DELETE, 7'd1,  32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_INS_AT, 7'd0,  32'sd9,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_INS_AT, 7'd2,  32'sd9,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_HEAD,   7'd0,  32'sh7fffffff, 1'b1, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd1);
    table_row(ple_pkg::OP_TAIL,   7'd0,  32'sh80000000, 1'b1, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd2);
    table_row(ple_pkg::OP_READ,   7'd1,  32'sd0,        1'b1, ple_pkg::ST_OK,
              32'h7fffffff, 7'd0, 7'd2);
    table_row(ple_pkg::OP_READ,   7'd2,  32'sd0,        1'b1, ple_pkg::ST_OK,
              32'h80000000, 7'd0, 7'd2);
    table_row(ple_pkg::OP_READ,   7'd0,  32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd2);
    table_row(ple_pkg::OP_READ,   7'd3,  32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd2);
    // find ignores the position field
    table_row(ple_pkg::OP_FIND,   7'd64, 32'sh80000000, 1'b1, ple_pkg::ST_OK,
              32'h80000000, 7'd2, 7'd2);
    table_row(ple_pkg::OP_INS_AT, 7'd3,  -32'sd1,       1'b1, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd3);
    table_row(ple_pkg::OP_INS_AT, 7'd2,  32'sd0,        1'b0, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_HEAD,   7'd64, 32'sd1,        1'b0, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_FIND,   7'd0,  -32'sd1,       1'b0, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    // unused opcode: no change, status ok
    table_row(OP_UNUSED,          7'd64, -32'sd1,       1'b1, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd5);
    table_row(ple_pkg::OP_DELETE, 7'd5,  32'sd0,        1'b0, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_DELETE, 7'd1,  32'sd0,        1'b0, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_TAIL,   7'd64, 32'sd0,        1'b0, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_READ,   7'd64, 32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd4);
    table_row(ple_pkg::OP_CLEAR,  7'd64, -32'sd1,       1'b1, ple_pkg::ST_OK,
              32'h0, 7'd0, 7'd0);
    table_row(ple_pkg::OP_READ,   7'd1,  32'sd0,        1'b1, ple_pkg::ST_BADPOS,
              32'h0, 7'd0, 7'd0);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                 directed_rows[i].pinned, directed_rows[i].res);

    // Random part: blocks of sequences that grow, fill up, shrink or just scramble
    mode = MODE_GROW;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BLOCK_WORDS == 0) begin
        case ((n / BLOCK_WORDS) % 8)
          1, 2, 3: mode = MODE_FILL;
          4, 7:    mode = MODE_SHRINK;
          5:       mode = MODE_NOISE;
          default: mode = MODE_GROW;
        endcase
      end
      no_idle = (n >= BURST_FROM && n < BURST_TO);
      if (n == HOLD_AT) long_hold_req = 1'b1;
      // pause the input until every result word is back
      if (n == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      random_word(mode);
    end
    in_valid_i <= 1'b0;

    for (n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      mismatch_count++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("positional_list_engine_unit: match");
    end else begin
      $display("positional_list_engine_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("positional_list_engine_unit: mismatch");
    $finish;
  end

endmodule
